FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the rate limiter top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("assert");
`define ASSERT_NEVER(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error("never");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, prop)
`endif
`endif

FILE: hw/rtl/prl_pkg.sv
// Types and constants for the per-connection rate limiter.
package prl_pkg;
  localparam int unsigned TableEntriesDefault = 16;

  localparam logic [1:0] CmdTick  = 2'd0;
  localparam logic [1:0] CmdMsg   = 2'd1;
  localparam logic [1:0] CmdQuery = 2'd2;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StOversize = 2'd1;
  localparam logic [1:0] StRate     = 2'd2;
  localparam logic [1:0] StFull     = 2'd3;

  localparam logic [2:0] RegWinLen  = 3'd0;
  localparam logic [2:0] RegMaxBytes = 3'd1;
  localparam logic [2:0] RegMaxMsgs = 3'd2;
  localparam logic [2:0] RegGuard   = 3'd3;
  localparam logic [2:0] RegRatio   = 3'd4;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [47:0] time_ms;
    logic [63:0] conn_id;
    logic [15:0] request_bytes;
    logic [23:0] response_bytes;
  } req_t;

  typedef struct packed {
    logic        allowed;
    logic [1:0]  status;
    logic [31:0] dropped_total;
  } rsp_t;

  typedef struct packed {
    logic [31:0] window_length_ms;
    logic [15:0] max_message_bytes;
    logic [15:0] max_messages_in_window;
    logic        guard_enable;
    logic [7:0]  response_ratio;
  } cfg_t;
endpackage

FILE: hw/rtl/per_connection_rate_limiter.sv
// Top level of the per-connection fixed-window rate limiter.
//  channel | direction | handshake
//  cmd     | in        | start_i && !busy_o
//  result  | out       | done_o strobe, one cycle
//  config  | in        | APB write, psel && penable && pwrite
// A tick runs the divider in SDiv, then passes SAct and is answered in SDone. A message
// scans one entry a cycle in SScan, then passes SAct and SDone; a query with the guard on
// adds SMul after SAct. An oversize message, a query with the guard off and an unused command
// go straight to SDone. After reset the table is empty and busy_o is low.
// The result cannot be stalled; busy_o is high from accept until the result strobe.
`include "assert_macros.svh"
module per_connection_rate_limiter #(
  parameter int unsigned TABLE_ENTRIES = prl_pkg::TableEntriesDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  prl_pkg::req_t req_i,
  output logic          done_o,
  output prl_pkg::rsp_t rsp_o,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import prl_pkg::*;
  localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SDiv  = 3'd1;
  localparam logic [2:0] SScan = 3'd2;
  localparam logic [2:0] SAct  = 3'd3;
  localparam logic [2:0] SMul  = 3'd4;
  localparam logic [2:0] SDone = 3'd5;

  cfg_t cfg;
  prl_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o(cfg)
  );

  logic [2:0] st_q;
  req_t req_q;
  logic [47:0] win_q;
  logic [31:0] drop_q;
  logic [TABLE_ENTRIES-1:0] valid_q;
  logic [63:0] conn_q [TABLE_ENTRIES];
  logic [15:0] cnt_q  [TABLE_ENTRIES];
  logic        hs_q   [TABLE_ENTRIES];
  logic [15:0] ls_q   [TABLE_ENTRIES];
  logic [IW:0] idx_q;
  logic        hit_q, free_q;
  logic [IW-1:0] hidx_q, fidx_q;
  logic [39:0] prod_q;
  logic        allowed_q;
  logic [1:0]  status_q;
  logic        div_start;
  logic        div_done;
  logic [47:0] div_quo;

  logic [IW-1:0] si;
  assign si = idx_q[IW-1:0];

  assign div_start = (st_q == SIdle) && start_i && (req_i.cmd == CmdTick);

  prl_divider u_div (
    .clk_i, .rst_ni,
    .start_i(div_start),
    .dividend_i(req_i.time_ms),
    .divisor_i(cfg.window_length_ms),
    .done_o(div_done),
    .quotient_o(div_quo)
  );

  assign busy_o = (st_q != SIdle);
  assign done_o = (st_q == SDone);
  assign rsp_o = '{allowed: allowed_q, status: status_q, dropped_total: drop_q};

  logic [15:0] base;
  always_comb begin
    base = req_q.request_bytes;
    if (hit_q) begin
      if (hs_q[hidx_q]) base = ls_q[hidx_q];
      if (base == 16'd0) base = 16'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == SIdle && start_i) req_q <= req_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle;
      win_q <= '0;
      drop_q <= '0;
      valid_q <= '0;
      idx_q <= '0;
      hit_q <= 1'b0;
      free_q <= 1'b0;
      hidx_q <= '0;
      fidx_q <= '0;
      allowed_q <= 1'b0;
      status_q <= StOk;
      prod_q <= '0;
    end else begin
      case (st_q)
        SIdle: if (start_i) begin
          idx_q <= '0;
          hit_q <= 1'b0;
          free_q <= 1'b0;
          allowed_q <= 1'b0;
          status_q <= StOk;
          case (req_i.cmd)
            CmdTick: st_q <= SDiv;
            CmdMsg: begin
              if (req_i.request_bytes > cfg.max_message_bytes) begin
                status_q <= StOversize;
                if (drop_q != 32'hFFFF_FFFF) drop_q <= drop_q + 32'd1;
                st_q <= SDone;
              end else st_q <= SScan;
            end
            CmdQuery: begin
              if (!cfg.guard_enable) begin
                allowed_q <= 1'b1;
                st_q <= SDone;
              end else st_q <= SScan;
            end
            default: st_q <= SDone;
          endcase
        end
        SDiv: begin
          if (div_done) st_q <= SAct;
        end
        SScan: begin
          if (valid_q[si] && conn_q[si] == req_q.conn_id && !hit_q) begin
            hit_q <= 1'b1;
            hidx_q <= si;
          end
          if (!valid_q[si] && !free_q) begin
            free_q <= 1'b1;
            fidx_q <= si;
          end
          idx_q <= idx_q + 1'b1;
          if (idx_q == (IW+1)'(TABLE_ENTRIES - 1)) st_q <= SAct;
        end
        SAct: begin
          st_q <= SDone;
          case (req_q.cmd)
            CmdTick: begin
              if (div_quo != win_q) valid_q <= '0;
              win_q <= div_quo;
              allowed_q <= 1'b1;
            end
            CmdMsg: begin
              if (!hit_q && !free_q) begin
                status_q <= StFull;
                if (drop_q != 32'hFFFF_FFFF) drop_q <= drop_q + 32'd1;
              end else begin
                if (!hit_q) valid_q[fidx_q] <= 1'b1;
                if ((hit_q ? cnt_q[hidx_q] : 16'd0) >= cfg.max_messages_in_window) begin
                  status_q <= StRate;
                  if (drop_q != 32'hFFFF_FFFF) drop_q <= drop_q + 32'd1;
                end else allowed_q <= 1'b1;
              end
            end
            default: begin
              prod_q <= {24'd0, base} * {32'd0, cfg.response_ratio};
              st_q <= SMul;
            end
          endcase
        end
        SMul: begin
          allowed_q <= ({16'd0, req_q.response_bytes} <= prod_q);
          st_q <= SDone;
        end
        SDone: st_q <= SIdle;
        default: st_q <= SIdle;
      endcase
    end
  end

  logic [IW-1:0] widx;
  logic [15:0]   ccur;
  assign widx = hit_q ? hidx_q : fidx_q;
  assign ccur = hit_q ? cnt_q[hidx_q] : 16'd0;

  always_ff @(posedge clk_i) begin
    if (st_q == SAct && req_q.cmd == CmdMsg && (hit_q || free_q)) begin
      if (!hit_q) conn_q[widx] <= req_q.conn_id;
      if (ccur < cfg.max_messages_in_window) begin
        cnt_q[widx] <= ccur + 16'd1;
        hs_q[widx] <= 1'b1;
        ls_q[widx] <= req_q.request_bytes;
      end else if (!hit_q) begin
        cnt_q[widx] <= 16'd0;
        hs_q[widx] <= 1'b0;
        ls_q[widx] <= 16'd0;
      end
    end
  end

  `ASSERT_NEVER(a_done_busy, clk_i, rst_ni, done_o && !busy_o)
  `ASSERT_IMPL(a_accept_busy, clk_i, rst_ni, (start_i && !busy_o) |=> busy_o)
  `ASSERT_IMPL(a_drop_mono, clk_i, rst_ni, $past(rst_ni) |-> drop_q >= $past(drop_q))
endmodule

FILE: hw/rtl/prl_regs.sv
// APB configuration registers of the rate limiter.
module prl_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output prl_pkg::cfg_t      cfg_o
);
  import prl_pkg::*;
  cfg_t cfg_q;
  logic [2:0] idx;
  assign idx = paddr[4:2];
  assign pready = 1'b1;
  assign cfg_o = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_length_ms <= 32'd1000;
      cfg_q.max_message_bytes <= 16'd1200;
      cfg_q.max_messages_in_window <= 16'd64;
      cfg_q.guard_enable <= 1'b1;
      cfg_q.response_ratio <= 8'd4;
    end else if (psel && penable && pwrite) begin
      case (idx)
        RegWinLen:   cfg_q.window_length_ms <= pwdata;
        RegMaxBytes: cfg_q.max_message_bytes <= pwdata[15:0];
        RegMaxMsgs:  cfg_q.max_messages_in_window <= pwdata[15:0];
        RegGuard:    cfg_q.guard_enable <= pwdata[0];
        RegRatio:    cfg_q.response_ratio <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegWinLen:   prdata = cfg_q.window_length_ms;
      RegMaxBytes: prdata = {16'd0, cfg_q.max_message_bytes};
      RegMaxMsgs:  prdata = {16'd0, cfg_q.max_messages_in_window};
      RegGuard:    prdata = {31'd0, cfg_q.guard_enable};
      RegRatio:    prdata = {24'd0, cfg_q.response_ratio};
      default:     prdata = 32'd0;
    endcase
  end
endmodule

FILE: hw/rtl/prl_divider.sv
// Restoring divider, one quotient bit per cycle, 48 by 32 bits.
module prl_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [47:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [47:0] quotient_o
);
  logic [47:0] quo_q, quo_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] div_q, div_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        run_q, run_d;
  logic        done_q, done_d;
  logic [32:0] trial;
  logic [33:0] diff;

  assign trial = {rem_q, quo_q[47]};
  assign diff = {1'b0, trial} - {2'b0, div_q};
  assign quotient_o = quo_q;
  assign done_o = done_q;

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    div_d = div_q;
    cnt_d = cnt_q;
    run_d = run_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d = dividend_i;
      rem_d = 32'd0;
      div_d = (divisor_i == 32'd0) ? 32'd1 : divisor_i;
      cnt_d = 6'd0;
      run_d = 1'b1;
    end else if (run_q) begin
      if (!diff[33]) begin
        rem_d = diff[31:0];
        quo_d = {quo_q[46:0], 1'b1};
      end else begin
        rem_d = trial[31:0];
        quo_d = {quo_q[46:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd47) begin
        run_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= 6'd0;
      done_q <= 1'b0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end
endmodule
